// ----- design/irsw_pkg.sv -----
// Shared types and constants for the windowed IR hit counter with argmax.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package irsw_pkg;

  // field widths fixed by the interface
  localparam int SENSOR_FIELD_W = 20;
  localparam int WINDOW_LEN_W   = 16;
  localparam int BEST_SENSOR_W  = 5;
  localparam int BEST_COUNT_W   = 8;
  localparam int CFG_DATA_W     = 20;
  localparam int CFG_IDX_W      = 1;

  // hit counter holds 0..256
  localparam int CNT_W = 9;

  // default number of sensors
  localparam int NUM_SENSORS_DEF = 20;

  // reset values of the configuration registers
  localparam logic [SENSOR_FIELD_W-1:0] ENABLE_RST     = 20'hFFFFF;
  localparam logic [WINDOW_LEN_W-1:0]   WINDOW_LEN_RST = 16'd128;

  // count thresholds
  localparam logic [CNT_W-1:0] CNT_SATURATE  = 9'd256;
  localparam logic [CNT_W-1:0] CNT_MIN_VALID = 9'd5;
  localparam logic [CNT_W-1:0] CNT_MAX_VALID = 9'd255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

  // result of one step of the shared evaluation unit
  typedef struct packed {
    logic [CNT_W-1:0]        new_count;
    logic                    take;
    logic [BEST_COUNT_W-1:0] value;
  } irsw_eval_t;

endpackage

`default_nettype wire

// ----- design/ir_sensor_ring_window_argmax.sv -----
// Each accepted poll is processed by one walk step per sensor through the shared
// evaluation unit, then the output load. in_stall is high during the walk and the
// output load, so a new poll is taken only after the previous result is loaded;
// that load waits while out_stall holds the previous result.
// Reset (rst_n low, synchronous): counters, poll position and held best cleared,
// sensor_enable = 0xFFFFF, window_length = 128, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module ir_sensor_ring_window_argmax
  import irsw_pkg::*;
#(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  // configuration port
  input  wire                       cfg_we,
  input  wire [CFG_IDX_W-1:0]       cfg_index,
  input  wire [CFG_DATA_W-1:0]      cfg_wdata,
  // input channel
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire [SENSOR_FIELD_W-1:0]  in_sensor_levels,
  // result channel
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic                      out_window_done,
  output logic [BEST_SENSOR_W-1:0]  out_best_sensor,
  output logic [BEST_COUNT_W-1:0]   out_best_count
);

  localparam int IDX_W  = $clog2(NUM_SENSORS);
  localparam int BIDX_W = $clog2(NUM_SENSORS + 1);
  localparam int POS_W  = WINDOW_LEN_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [SENSOR_FIELD_W-1:0] enable_r;
  logic [WINDOW_LEN_W-1:0]   wlen_r;
  logic [WINDOW_LEN_W-1:0]   pos_r, pos_nxt;
  logic                      closing_r, closing_nxt;
  logic [NUM_SENSORS-1:0]    hits_r, hits_nxt;
  logic [BEST_COUNT_W-1:0]   best_val_r, best_val_nxt;
  logic [BIDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic [BEST_COUNT_W-1:0]   held_cnt_r, held_cnt_nxt;
  logic [BIDX_W-1:0]         held_idx_r, held_idx_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_done_r;
  logic [BEST_SENSOR_W-1:0]  out_sensor_r;
  logic [BEST_COUNT_W-1:0]   out_count_r;

  logic                      in_acc;
  logic                      last_idx;
  logic                      out_load;
  logic [POS_W-1:0]          pos_inc;
  logic [POS_W-1:0]          limit;
  logic [CNT_W-1:0]          cnt_rd;
  logic                      bank_we;
  irsw_eval_t                eval;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign last_idx = (idx_r == IDX_W'(NUM_SENSORS - 1));
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign bank_we  = (state_r == ST_WALK);

  // window close decision and hit vector, taken at accept
  always_comb begin
    pos_inc = {1'b0, pos_r} + POS_W'(1);
    limit   = (wlen_r == '0) ? (POS_W'(1) << WINDOW_LEN_W) : {1'b0, wlen_r};
    closing_nxt = closing_r;
    pos_nxt     = pos_r;
    hits_nxt    = hits_r;
    if (in_acc) begin
      closing_nxt = (pos_inc >= limit);
      pos_nxt     = closing_nxt ? '0 : pos_inc[WINDOW_LEN_W-1:0];
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (i < SENSOR_FIELD_W) begin
          hits_nxt[i] = enable_r[i] && !in_sensor_levels[i];
        end else begin
          hits_nxt[i] = 1'b0;
        end
      end
    end
  end

  // counter storage
  irsw_count_bank #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (bank_we),
    .addr  (idx_r),
    .wdata (eval.new_count),
    .rdata (cnt_rd)
  );

  // shared increment / filter / compare unit
  irsw_eval_unit u_eval (
    .count    (cnt_rd),
    .hit      (hits_r[idx_r]),
    .closing  (closing_r),
    .best_val (best_val_r),
    .res      (eval)
  );

  // sequencer: walk the sensors one per cycle, then hand off the result
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    held_cnt_nxt = held_cnt_r;
    held_idx_nxt = held_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt    = ST_WALK;
          idx_nxt      = '0;
          best_val_nxt = '0;
          best_idx_nxt = '0;
        end
      end
      ST_WALK: begin
        if (eval.take) begin
          best_val_nxt = eval.value;
          best_idx_nxt = BIDX_W'(idx_r) + BIDX_W'(1);
        end
        if (last_idx) begin
          state_nxt = ST_DONE;
          idx_nxt   = '0;
          if (closing_r) begin
            held_cnt_nxt = best_val_nxt;
            held_idx_nxt = best_idx_nxt;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid tracking
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      enable_r    <= ENABLE_RST;
      wlen_r      <= WINDOW_LEN_RST;
      pos_r       <= '0;
      closing_r   <= 1'b0;
      held_cnt_r  <= '0;
      held_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      closing_r   <= closing_nxt;
      held_cnt_r  <= held_cnt_nxt;
      held_idx_r  <= held_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SENSOR_ENABLE: enable_r <= cfg_wdata[SENSOR_FIELD_W-1:0];
          REG_WINDOW_LENGTH: wlen_r   <= cfg_wdata[WINDOW_LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    hits_r     <= hits_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    if (out_load) begin
      out_done_r   <= closing_r;
      out_sensor_r <= BEST_SENSOR_W'(held_idx_r);
      out_count_r  <= held_cnt_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_window_done = out_done_r;
  assign out_best_sensor = out_sensor_r;
  assign out_best_count  = out_count_r;

  // an accepted poll always starts a walk
  a_acc_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_WALK))
    else $error("accepted poll did not start the sensor walk");

  // held best index is nonzero exactly when the held count is
  a_held_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (held_cnt_r == '0) == (held_idx_r == '0))
    else $error("held best index and count disagree");

  // walk index rests at zero outside the walk
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_WALK) |-> (idx_r == '0))
    else $error("walk index not at zero outside the walk");

  // a new result is only loaded when the output register is free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_count_r) && $stable(out_sensor_r))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- design/irsw_count_bank.sv -----
// Bank of per-sensor hit counters, one read and one write port on a shared address.
// Depends on irsw_pkg for the counter width.
`timescale 1ns / 1ps
`default_nettype none

module irsw_count_bank
  import irsw_pkg::*;
#(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             we,
  input  wire [$clog2(NUM_SENSORS)-1:0]   addr,
  input  wire [CNT_W-1:0]                 wdata,
  output logic [CNT_W-1:0]                rdata
);

  logic [CNT_W-1:0] cnt_r [NUM_SENSORS];

  // counters clear at reset, one entry written per cycle while we is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (we) begin
      cnt_r[addr] <= wdata;
    end
  end

  assign rdata = cnt_r[addr];

endmodule

`default_nettype wire

// ----- design/irsw_eval_unit.sv -----
// Shared per-sensor unit: saturating increment, window-end filter and compare.
// Depends on irsw_pkg for widths, thresholds and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module irsw_eval_unit
  import irsw_pkg::*;
(
  input  wire [CNT_W-1:0]        count,
  input  wire                    hit,
  input  wire                    closing,
  input  wire [BEST_COUNT_W-1:0] best_val,
  output irsw_eval_t             res
);

  logic [CNT_W-1:0]        cnt_inc;
  logic [BEST_COUNT_W-1:0] filt;

  // saturating increment
  always_comb begin
    if (hit && (count != CNT_SATURATE)) begin
      cnt_inc = count + CNT_W'(1);
    end else begin
      cnt_inc = count;
    end
  end

  // counts outside the valid band count as zero
  always_comb begin
    if ((cnt_inc >= CNT_MIN_VALID) && (cnt_inc <= CNT_MAX_VALID)) begin
      filt = cnt_inc[BEST_COUNT_W-1:0];
    end else begin
      filt = '0;
    end
  end

  // strictly larger wins, so ties keep the lower index
  assign res.take      = closing && (filt > best_val);
  assign res.value     = filt;
  assign res.new_count = closing ? '0 : cnt_inc;

endmodule

`default_nettype wire
